@@ sv/mpeq_pkg.sv @@
`timescale 1ns / 1ps

package mpeq_pkg;

    localparam int FILTER_TAPS_DEF = 5;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int WINDOW_W        = 5;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 2;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_CALIB = 2'd1;
    localparam logic [1:0] MODE_READY = 2'd2;
    localparam logic [1:0] MODE_ACERR = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_BEGIN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_POL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_EDGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd3;

    localparam logic             EDGE_POL_RST  = 1'b1;
    localparam logic [CFG_W-1:0] PULSE_END_RST = 8'd9;
    localparam logic [CFG_W-1:0] MISS_EDGE_RST = 8'd102;
    localparam logic [CFG_W-1:0] MIN_GAP_RST   = 8'd97;

    typedef struct packed {
        logic             edge_pol;
        logic [CFG_W-1:0] pulse_end;
        logic [CFG_W-1:0] miss_edge;
        logic [CFG_W-1:0] min_gap;
    } t_cfg;

    typedef struct packed {
        logic                func;
        logic                sample;
        logic [WINDOW_W-1:0] window;
    } t_item;

    typedef struct packed {
        logic       catch_pulse;
        logic [1:0] mode;
        logic       level;
    } t_result;

endpackage

@@ sv/mpeq_ifs.sv @@
`timescale 1ns / 1ps

interface mpeq_in_if import mpeq_pkg::*;;
    logic                valid;
    logic                ready;
    logic                func;
    logic                sample;
    logic [WINDOW_W-1:0] window;

    modport source (output valid, output func, output sample, output window, input ready);
    modport sink   (input valid, input func, input sample, input window, output ready);
endinterface

interface mpeq_out_if;
    logic       valid;
    logic       ready;
    logic       catch_pulse;
    logic [1:0] mode;
    logic       level;

    modport source (output valid, output catch_pulse, output mode, output level, input ready);
    modport sink   (input valid, input catch_pulse, input mode, input level, output ready);
endinterface

interface mpeq_cfg_if import mpeq_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/mpeq_cfg.sv @@
`timescale 1ns / 1ps

module mpeq_cfg import mpeq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_pol  <= EDGE_POL_RST;
            r_cfg.pulse_end <= PULSE_END_RST;
            r_cfg.miss_edge <= MISS_EDGE_RST;
            r_cfg.min_gap   <= MIN_GAP_RST;
        end else if (i_wr) begin
            unique case (i_index)
                REG_EDGE_POL:  r_cfg.edge_pol  <= i_data[0];
                REG_PULSE_END: r_cfg.pulse_end <= i_data;
                REG_MISS_EDGE: r_cfg.miss_edge <= i_data;
                REG_MIN_GAP:   r_cfg.min_gap   <= i_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/mpeq_step.sv @@
`timescale 1ns / 1ps

module mpeq_step import mpeq_pkg::*; #(
    parameter int FILTER_TAPS = FILTER_TAPS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int ONES_W  = $clog2(FILTER_TAPS + 1);
    localparam int MAJ_LIM = FILTER_TAPS / 2;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [FILTER_TAPS-1:0] r_hist, n_hist;
    logic                   r_level, n_level;
    logic                   r_in_pulse, n_in_pulse;
    logic [COUNT_BITS-1:0]  r_tick, n_tick;
    logic [COUNT_BITS-1:0]  r_bad, n_bad;
    logic [COUNT_BITS-1:0]  r_good, n_good;
    logic [1:0]             r_mode, n_mode;
    logic                   n_fire;

    logic [FILTER_TAPS+WINDOW_W-1:0] w_ext;
    logic [FILTER_TAPS-1:0]          w_seed;
    logic [FILTER_TAPS-1:0]          w_shift;
    logic                            w_lvl;
    logic                            w_seed_lvl;
    logic [COUNT_BITS-1:0]           w_bad_dec;
    logic [COUNT_BITS-1:0]           w_good_dec;
    logic [COUNT_BITS-1:0]           w_pend;
    logic [COUNT_BITS-1:0]           w_miss;
    logic [COUNT_BITS-1:0]           w_gap;

    function automatic logic majority(input logic [FILTER_TAPS-1:0] h);
        logic [ONES_W-1:0] ones;
        ones = '0;
        for (int i = 0; i < FILTER_TAPS; i++) begin
            ones = ones + ONES_W'(h[i]);
        end
        return ones > ONES_W'(MAJ_LIM);
    endfunction

    assign w_ext      = {{FILTER_TAPS{1'b0}}, i_item.window};
    assign w_seed     = w_ext[FILTER_TAPS-1:0];
    assign w_shift    = {r_hist[FILTER_TAPS-2:0], i_item.sample};
    assign w_lvl      = majority(w_shift);
    assign w_seed_lvl = majority(w_seed);
    assign w_bad_dec  = r_bad - CNT_ONE;
    assign w_good_dec = r_good - CNT_ONE;
    assign w_pend     = COUNT_BITS'(i_cfg.pulse_end);
    assign w_miss     = COUNT_BITS'(i_cfg.miss_edge);
    assign w_gap      = COUNT_BITS'(i_cfg.min_gap);

    always_comb begin
        n_hist     = r_hist;
        n_level    = r_level;
        n_in_pulse = r_in_pulse;
        n_tick     = r_tick;
        n_bad      = r_bad;
        n_good     = r_good;
        n_mode     = r_mode;
        n_fire     = 1'b0;
        if (i_item.func == FUNC_BEGIN) begin
            n_hist  = w_seed;
            n_level = w_seed_lvl;
            n_mode  = MODE_CALIB;
            n_tick  = CNT_MAX - CNT_ONE;
            n_bad   = CNT_MAX;
            n_good  = CNT_MAX;
        end else if (r_mode != MODE_IDLE) begin
            n_hist = w_shift;
            if (w_lvl == r_level) begin
                if (r_in_pulse) begin
                    if (r_tick == w_pend) begin
                        n_tick     = CNT_MAX;
                        n_in_pulse = 1'b0;
                        n_fire     = (r_mode == MODE_READY);
                    end
                end else if (r_tick >= w_miss) begin
                    n_tick = CNT_MAX;
                    n_good = CNT_MAX;
                    n_bad  = w_bad_dec;
                    if (w_bad_dec == '0) begin
                        n_mode = MODE_ACERR;
                    end
                end
                n_tick = n_tick + CNT_ONE;
            end else begin
                n_level = w_lvl;
                if (w_lvl == i_cfg.edge_pol) begin
                    n_in_pulse = 1'b1;
                    n_tick     = '0;
                    if (r_mode == MODE_CALIB) begin
                        n_mode = MODE_READY;
                    end else if (r_tick > w_gap) begin
                        n_bad  = CNT_MAX;
                        n_fire = (r_mode == MODE_READY);
                        n_good = w_good_dec;
                        if (w_good_dec == '0) begin
                            n_mode = MODE_READY;
                        end
                    end else begin
                        n_good = CNT_MAX;
                        n_bad  = w_bad_dec;
                        if (w_bad_dec == '0) begin
                            n_mode = MODE_ACERR;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_level    <= 1'b0;
            r_in_pulse <= 1'b0;
            r_tick     <= '0;
            r_bad      <= CNT_MAX;
            r_good     <= CNT_MAX;
            r_mode     <= MODE_IDLE;
        end else if (i_en) begin
            r_hist     <= n_hist;
            r_level    <= n_level;
            r_in_pulse <= n_in_pulse;
            r_tick     <= n_tick;
            r_bad      <= n_bad;
            r_good     <= n_good;
            r_mode     <= n_mode;
        end
    end

    assign o_res.catch_pulse = n_fire;
    assign o_res.mode        = n_mode;
    assign o_res.level       = n_level;

endmodule

@@ sv/mains_phase_edge_qualifier.sv @@
`timescale 1ns / 1ps

// channel   port    direction  payload
// ------------------------------------------------------------
// input     i_in    sink       func, sample, window[4:0]
// result    o_out   source     catch_pulse, mode[1:0], level
// config    i_cfg   sink       index[1:0], data[7:0]
//
// One item per cycle while results are taken; each item passes the input
// register, then the filter/counter update lands in the result register.
// Reset is synchronous: mode idle, history and tick count cleared, good and
// bad countdowns at all ones, registers back to defaults. Config writes are
// always taken.
// A stalled result holds; input ready drops only when both registers are full.

module mains_phase_edge_qualifier import mpeq_pkg::*; #(
    parameter int FILTER_TAPS = FILTER_TAPS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpeq_in_if.sink    i_in,
    mpeq_out_if.source o_out,
    mpeq_cfg_if.sink   i_cfg
);

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    logic    w_adv;
    logic    w_in_rdy;
    t_cfg    w_cfg;
    t_result w_res;

    assign w_adv    = r_in_vld && (!r_out_vld || o_out.ready);
    assign w_in_rdy = !r_in_vld || w_adv;

    assign i_in.ready  = w_in_rdy;
    assign i_cfg.ready = 1'b1;

    mpeq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    mpeq_step #(
        .FILTER_TAPS (FILTER_TAPS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_rdy) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_rdy) begin
            r_in.func   <= i_in.func;
            r_in.sample <= i_in.sample;
            r_in.window <= i_in.window;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.catch_pulse = r_out.catch_pulse;
    assign o_out.mode        = r_out.mode;
    assign o_out.level       = r_out.level;

endmodule

@@ sv/mpeq_checker.sv @@
`timescale 1ns / 1ps

module mpeq_checker import mpeq_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_catch,
    input logic [1:0] i_out_mode
);

    logic [1:0] r_pend;
    logic       r_seen;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_seen <= 1'b0;
        end else begin
            r_pend <= r_pend + 2'(w_in_acc) - 2'(w_out_acc);
            if (w_out_acc && i_out_mode != MODE_IDLE) begin
                r_seen <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != 2'd0))
        else $error("result without pending item");

    a_catch_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_catch) |-> (i_out_mode == MODE_READY))
        else $error("catch pulse outside ready mode");

    a_no_idle_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen && i_out_valid) |-> (i_out_mode != MODE_IDLE))
        else $error("mode went back to idle");

endmodule

bind mains_phase_edge_qualifier mpeq_checker u_mpeq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_catch (o_out.catch_pulse),
    .i_out_mode  (o_out.mode)
);
